>>> src/waveform_sample_generator_macros.svh
// assertion macros for the waveform sample generator
`ifndef WAVEFORM_SAMPLE_GENERATOR_MACROS_SVH
`define WAVEFORM_SAMPLE_GENERATOR_MACROS_SVH
// property that must hold at every rising clock edge outside reset
`define WSG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked through reset too
`define WSG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> src/wsg_pkg.sv
// package: types, constants and sine table for the waveform sample generator
package wsg_pkg;
   localparam int TableBits = 10;
   localparam int TableSize = 1 << TableBits;
   localparam logic [1:0] WAVE_SINE = 2'd0;
   localparam logic [1:0] WAVE_SAW  = 2'd1;
   localparam logic [15:0] DC_LEVEL = 16'h8000;
   localparam logic [1:0] REG_WAVE_TYPE = 2'd0;
   localparam logic [1:0] REG_PERIOD    = 2'd1;
   localparam logic [1:0] REG_AMPLITUDE = 2'd2;
   localparam logic [1:0] REG_COUNT     = 2'd3;

   // one classified beat from front to back
   typedef struct packed {
      logic        zero_out;
      logic        last;
      logic [1:0]  wave;
      logic [15:0] phase;
      logic [15:0] per;
      logic [15:0] amp;
   } job_type;

   // quarter-wave Q1.15 entry, integer Taylor series; evaluated at elaboration only
   function automatic logic [15:0] table_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      logic [63:0] r;
      x = (64'd1686629713 * 64'(i)) >> TableBits;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      return r[15:0];
   endfunction
endpackage

>>> src/wsg_stream_if.sv
// valid/ready stream interface
interface wsg_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

>>> src/waveform_sample_generator.sv
// waveform sample generator top level
// the back takes one tick's job at a time and works it through a bit-serial phase divider
// before it offers the sample beat; it accepts no new job until that beat is taken
// the two-entry queue holds up to two more ticks while the back works on one
// reset is synchronous, active high: index and phase go to 0, registers to defaults
module waveform_sample_generator #(
   parameter int IndexBits = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [16:0]          csr_write_data,
   wsg_stream_if.sink           req,
   wsg_stream_if.source         rsp
);
   // req.data[0] is start_req; rsp.data is {last, sample}
   wsg_pkg::job_type f_job, q_job;
   logic f_valid, f_ready, q_valid, q_ready;
   logic [15:0] sample;
   logic last;

   // front: counters and classification
   wsg_front #(.IndexBits(IndexBits)) u_front (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .start_req(req.data[0]), .in_valid(req.valid), .in_ready(req.ready),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   // decoupling queue
   wsg_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job));

   // back: arithmetic and output register
   wsg_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_sample(sample), .out_last(last));

   assign rsp.data = {last, sample};
endmodule

>>> src/wsg_divider.sv
// restoring divider, one quotient bit per cycle
module wsg_divider #(
   parameter int NumBits = 32,
   parameter int DenBits = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NumBits-1:0] num,
   input  logic [DenBits-1:0] den,
   output logic               done,
   output logic [NumBits-1:0] quot
);
   localparam int CntBits = $clog2(NumBits + 1);
   logic [NumBits-1:0] q_ff, q_in;
   logic [DenBits:0]   rem_ff, rem_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [DenBits:0]   trial;
   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[DenBits-1:0], q_ff[NumBits-1]};
      if (start) begin
         q_in = num;
         rem_in = '0;
         cnt_in = CntBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = trial - {1'b0, den};
            q_in = {q_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) busy_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
   end
   assign done = busy_ff && cnt_ff == CntBits'(1);
   assign quot = q_in;
endmodule

>>> src/wsg_front.sv
// front: accepts tick beats, tracks index and phase, classifies each sample
module wsg_front #(
   parameter int IndexBits = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [16:0]         csr_write_data,
   input  logic                start_req,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                job_valid,
   input  logic                job_ready,
   output wsg_pkg::job_type    job
);
   localparam logic [IndexBits:0] MaxCount = (IndexBits+1)'(1) << IndexBits;
   logic [1:0]  wave_ff;
   logic [15:0] period_ff, amp_ff;
   logic [16:0] count_ff;
   logic [IndexBits-1:0] idx_ff, idx_in;
   logic [15:0] ph_ff, ph_in;
   logic [15:0] per, amp, n_ph;
   logic [IndexBits:0] cnt;
   logic [IndexBits-1:0] n_idx;
   logic        is_last;
   logic        fire;
   always_comb begin
      per = (period_ff == '0) ? 16'd1 : period_ff;
      amp = (amp_ff < 16'd2) ? 16'd2 : amp_ff;
      if (count_ff == '0) cnt = (IndexBits+1)'(1);
      else if ({{(IndexBits+1){1'b0}}, count_ff} > {17'd0, MaxCount}) cnt = MaxCount;
      else cnt = (IndexBits+1)'(count_ff);
      n_idx = idx_ff;
      n_ph = ph_ff;
      if (start_req || {1'b0, idx_ff} >= cnt) begin
         n_idx = '0;
         n_ph = '0;
      end
      if (n_ph >= per) n_ph = '0;
      is_last = ({1'b0, n_idx} == cnt - 1'b1);
      idx_in = is_last ? '0 : n_idx + 1'b1;
      ph_in = (is_last || {1'b0, n_ph} + 17'd1 >= {1'b0, per}) ? 16'd0 : n_ph + 16'd1;
      job.zero_out = is_last && cnt[0];
      job.last = is_last;
      job.wave = wave_ff;
      job.phase = n_ph;
      job.per = per;
      job.amp = amp;
   end
   assign in_ready = job_ready;
   assign job_valid = in_valid;
   assign fire = in_valid && job_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= wsg_pkg::WAVE_SINE;
         period_ff <= 16'd2048;
         amp_ff <= 16'd16384;
         count_ff <= 17'd32768;
         idx_ff <= '0;
         ph_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               wsg_pkg::REG_WAVE_TYPE: wave_ff <= csr_write_data[1:0];
               wsg_pkg::REG_PERIOD:    period_ff <= csr_write_data[15:0];
               wsg_pkg::REG_AMPLITUDE: amp_ff <= csr_write_data[15:0];
               wsg_pkg::REG_COUNT:     count_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (fire) begin
            idx_ff <= idx_in;
            ph_ff <= ph_in;
         end
      end
   end
endmodule

>>> src/wsg_queue.sv
// two-entry job queue between front and back
module wsg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  wsg_pkg::job_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output wsg_pkg::job_type rd_data
);
   wsg_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] fill_ff;
   logic       wr, rd;
   assign wr_ready = fill_ff != 2'd2;
   assign rd_valid = fill_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         fill_ff <= fill_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

>>> src/wsg_back.sv
// back: divides phase, scales sine lookup or saw, gives DC level or zero, holds the result beat
module wsg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  wsg_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [15:0]      out_sample,
   output logic             out_last
);
   localparam int TB = wsg_pkg::TableBits;
   // wide enough for the saw product phase * (amp - 1)
   localparam int NB = 32;
   localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_MUL = 2'd2, S_OUT = 2'd3;
   logic [15:0] sine_rom [wsg_pkg::TableSize];
   for (genvar g = 0; g < wsg_pkg::TableSize; g++) begin : g_rom
      assign sine_rom[g] = wsg_pkg::table_entry(g);
   end
   logic [1:0]  st_ff;
   wsg_pkg::job_type job_ff;
   logic [31:0] prod_ff;
   logic [NB-1:0] num;
   logic        dv_start, dv_done;
   logic [NB-1:0] quot;
   logic [15:0] mag_ff, s_ff;
   logic [1:0]  quad_ff;
   logic [TB-1:0] r;
   logic [TB:0] rr;
   logic [15:0] mag, ampl, v;
   logic [31:0] mp;
   logic        last_ff;
   always_comb begin
      if (job.wave == wsg_pkg::WAVE_SAW) num = 32'(job.phase) * 32'(job.amp - 16'd1);
      else num = NB'({job.phase, {(TB+2){1'b0}}});
      r = quot[TB-1:0];
      rr = quot[TB] ? (TB+1)'(wsg_pkg::TableSize) - {1'b0, r} : {1'b0, r};
      mag = rr[TB] ? 16'd32767 : sine_rom[rr[TB-1:0]];
      ampl = job_ff.amp / 16'd2 - 16'd1;
      mp = mag_ff * ampl;
      v = mp[30:15];
   end
   assign dv_start = st_ff == S_IDLE && job_valid;
   assign job_ready = st_ff == S_IDLE;
   // divisor comes from the captured job, the queue head moves on at start
   wsg_divider #(.NumBits(NB), .DenBits(16)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(num), .den(job_ff.per),
      .done(dv_done), .quot(quot));
   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else begin
         case (st_ff)
            S_IDLE: if (job_valid) st_ff <= S_DIV;
            S_DIV:  if (dv_done) st_ff <= S_MUL;
            S_MUL:  st_ff <= S_OUT;
            S_OUT:  if (out_ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
      if (dv_start) job_ff <= job;
      if (st_ff == S_DIV && dv_done) begin
         mag_ff <= mag;
         quad_ff <= quot[TB+1:TB];
         prod_ff <= {quot[30:0], 1'b0};
      end
      if (st_ff == S_MUL) begin
         last_ff <= job_ff.last;
         if (job_ff.zero_out) s_ff <= '0;
         else if (job_ff.wave == wsg_pkg::WAVE_SINE) s_ff <= quad_ff[1] ? 16'd0 - v : v;
         else if (job_ff.wave == wsg_pkg::WAVE_SAW) s_ff <= prod_ff[15:0];
         else s_ff <= wsg_pkg::DC_LEVEL;
      end
   end
   assign out_valid = st_ff == S_OUT;
   assign out_sample = s_ff;
   assign out_last = last_ff;
   logic unused;
   assign unused = ^prod_ff[31:16];
endmodule

>>> src/wsg_checker.sv
// port-level checker for the waveform sample generator, bound to the top level
`include "waveform_sample_generator_macros.svh"
module wsg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_data
);
   `WSG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result beat changed while stalled")
   `WSG_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result beat right after reset")
   `WSG_ASSERT(a_one_beat, clock, reset, rsp_valid && rsp_ready |=> !rsp_valid, "result beats back to back")
   logic unused;
   assign unused = req_valid ^ req_ready;
endmodule

bind waveform_sample_generator wsg_checker u_wsg_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

>>> tb/tb.sv
// testbench for the waveform sample generator: directed table, then randomized config phases
module tb;
   localparam logic [1:0] WAVE_DC     = 2'd2;
   localparam logic [1:0] WAVE_DC_ALT = 2'd3;
   localparam int         ENTRIES     = 1 << 10;
   localparam int         PHASES      = 14;
   localparam int         PHASE_BEATS = 130;
   localparam int         HOLD_CYCLES = 400;

   // one row of the directed table: a register write or a tick beat
   typedef struct {
      bit          is_write;
      logic [1:0]  reg_sel;
      logic [16:0] value;
      bit          start;
      bit          typed;
      logic [15:0] want_sample;
      bit          want_last;
   } row_type;

   typedef struct {
      logic [15:0] sample;
      bit          last;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_write_data = '0;

   wsg_stream_if #(.Width(1))  req ();
   wsg_stream_if #(.Width(17)) rsp ();

   waveform_sample_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .rsp              (rsp)
   );

   always #5 clock = ~clock;

   // predictor state: register copies, buffer position, quarter-wave table
   logic [15:0] quarter_sine [ENTRIES];
   logic [1:0]  cur_wave;
   int unsigned cur_period, cur_amp, cur_count;
   int unsigned buf_pos, wave_phase;
   sample_type  pending_samples[$];
   int          error_count = 0;
   bit          hold_req = 0;
   bit          hold_done = 0;

   // Q1.15 sine of pi/2 * i / 1024 by integer Taylor series, rounded, capped
   function automatic logic [15:0] quarter_value(input int unsigned i);
      longint unsigned x, x2, term, r;
      longint          acc;
      x = (64'd1686629713 * 64'(i)) >> 10;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      r = (64'(acc) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      return r[15:0];
   endfunction

   function automatic int unsigned quarter_mag(input int unsigned j);
      if (j >= ENTRIES) return 32767;
      return 32'(quarter_sine[j]);
   endfunction

   // next sample of the configured waveform; advances index and phase
   function automatic sample_type next_sample(input bit start);
      sample_type      o;
      int unsigned     per, amp, cnt, n, p, q, r, mag, v;
      longint unsigned k;
      per = (cur_period == 0) ? 1 : cur_period;
      amp = (cur_amp < 2) ? 2 : cur_amp;
      cnt = (cur_count == 0) ? 1 : cur_count;
      if (cnt > 65536) cnt = 65536;
      if (start || buf_pos >= cnt) begin
         buf_pos = 0;
         wave_phase = 0;
      end
      if (wave_phase >= per) wave_phase = 0;
      n = buf_pos;
      p = wave_phase;
      o.last = (n == cnt - 1);
      if (o.last && cnt[0]) begin
         o.sample = 16'h0;
      end else if (cur_wave == wsg_pkg::WAVE_SINE) begin
         k = (64'(p) << 12) / 64'(per);
         q = 32'((k >> 10) & 64'd3);
         r = 32'(k & 64'(ENTRIES - 1));
         mag = q[0] ? quarter_mag(ENTRIES - r) : quarter_mag(r);
         v = (mag * (amp / 2 - 1)) >> 15;
         if (q[1]) v = 0 - v;
         o.sample = v[15:0];
      end else if (cur_wave == wsg_pkg::WAVE_SAW) begin
         k = (64'(p) * 64'(amp - 1)) / 64'(per) * 2;
         o.sample = k[15:0];
      end else begin
         o.sample = wsg_pkg::DC_LEVEL;
      end
      if (o.last) begin
         buf_pos = 0;
         wave_phase = 0;
      end else begin
         buf_pos = n + 1;
         wave_phase = (p + 1 >= per) ? 0 : p + 1;
      end
      return o;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // register write, only once the block has drained; caller is at a rising edge
   task automatic write_reg(input logic [1:0] sel, input logic [16:0] value);
      req.valid <= 1'b0;
      wait (pending_samples.size() == 0);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (sel)
         wsg_pkg::REG_WAVE_TYPE: cur_wave = value[1:0];
         wsg_pkg::REG_PERIOD:    cur_period = 32'(value[15:0]);
         wsg_pkg::REG_AMPLITUDE: cur_amp = 32'(value[15:0]);
         wsg_pkg::REG_COUNT:     cur_count = 32'(value);
         default: ;
      endcase
   endtask

   // offer one tick beat; caller is at a rising edge. valid stays high when no gap follows
   task automatic send_tick(input bit start, input bit typed, input sample_type want);
      sample_type predicted;
      int         gap;
      req.valid <= 1'b1;
      req.data <= start;
      // ready is settled by the falling edge, so the beat goes at the next rising edge
      forever begin
         @(negedge clock);
         if (req.ready) break;
      end
      @(posedge clock);
      predicted = next_sample(start);
      pending_samples.insert(pending_samples.size(), typed ? want : predicted);
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic row_type tick_row(input bit start, input bit typed,
                                        input logic [15:0] smp, input bit lst);
      row_type t;
      t = '{default: 0};
      t.start = start;
      t.typed = typed;
      t.want_sample = smp;
      t.want_last = lst;
      return t;
   endfunction

   function automatic row_type write_row(input logic [1:0] sel, input logic [16:0] value);
      row_type t;
      t = '{default: 0};
      t.is_write = 1;
      t.reg_sel = sel;
      t.value = value;
      return t;
   endfunction

   row_type directed[$];

   // append one row to the directed table
   function automatic void add_row(input row_type t);
      directed.insert(directed.size(), t);
   endfunction

   // receiver: random stalls, plus one long hold-off while the sender keeps offering
   initial begin
      int gap;
      rsp.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // result beats: sample in the low 16 bits, last flag in bit 16
   always @(negedge clock) begin
      sample_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_samples.size() == 0) begin
            report("unexpected sample beat", 32'(rsp.data), 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp.data[15:0] !== want.sample) report("sample", rsp.data[15:0], want.sample);
            if (rsp.data[16] !== want.last) report("last", rsp.data[16], want.last);
         end
      end
   end

   // limit on the whole run
   initial begin
      #6000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sample_type  typed_val;
      logic [16:0] val;
      int          beats;
      req.valid <= 1'b0;
      req.data <= '0;
      for (int i = 0; i < ENTRIES; i++) quarter_sine[i] = quarter_value(i);
      cur_wave = wsg_pkg::WAVE_SINE;
      cur_period = 2048;
      cur_amp = 16384;
      cur_count = 32768;
      buf_pos = 0;
      wave_phase = 0;

      // directed part: defaults, DC buffers, odd final sample, open register cases
      add_row(tick_row(1, 1, 16'h0000, 0));   // sine at phase zero after reset
      add_row(tick_row(0, 0, 0, 0));
      add_row(tick_row(0, 0, 0, 0));
      add_row(write_row(wsg_pkg::REG_WAVE_TYPE, WAVE_DC));
      add_row(write_row(wsg_pkg::REG_COUNT, 17'd2));
      add_row(tick_row(1, 1, wsg_pkg::DC_LEVEL, 0));
      add_row(tick_row(0, 1, wsg_pkg::DC_LEVEL, 1));
      add_row(write_row(wsg_pkg::REG_COUNT, 17'd3));  // odd count: final sample zero
      add_row(tick_row(0, 1, wsg_pkg::DC_LEVEL, 0));
      add_row(tick_row(0, 1, wsg_pkg::DC_LEVEL, 0));
      add_row(tick_row(0, 1, 16'h0000, 1));
      add_row(write_row(wsg_pkg::REG_COUNT, 17'd1));  // single-sample buffer
      add_row(tick_row(0, 1, 16'h0000, 1));
      add_row(write_row(wsg_pkg::REG_COUNT, 17'd0));  // zero count acts as one
      add_row(tick_row(1, 1, 16'h0000, 1));
      add_row(write_row(wsg_pkg::REG_WAVE_TYPE, wsg_pkg::WAVE_SAW));
      add_row(write_row(wsg_pkg::REG_PERIOD, 17'd0)); // zero period acts as one
      add_row(write_row(wsg_pkg::REG_AMPLITUDE, 17'd1));
      add_row(write_row(wsg_pkg::REG_COUNT, 17'h1ffff)); // saturates to full index range
      add_row(tick_row(1, 1, 16'h0000, 0));
      add_row(tick_row(0, 0, 0, 0));
      add_row(write_row(wsg_pkg::REG_PERIOD, 17'd65535));
      add_row(write_row(wsg_pkg::REG_AMPLITUDE, 17'd65535));
      add_row(tick_row(0, 0, 0, 0));
      add_row(write_row(wsg_pkg::REG_WAVE_TYPE, wsg_pkg::WAVE_SINE));
      add_row(tick_row(0, 0, 0, 0));
      add_row(write_row(wsg_pkg::REG_WAVE_TYPE, WAVE_DC_ALT));
      add_row(write_row(wsg_pkg::REG_COUNT, 17'd2)); // index now beyond count
      add_row(tick_row(0, 1, wsg_pkg::DC_LEVEL, 0));
      add_row(tick_row(0, 1, wsg_pkg::DC_LEVEL, 1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            write_reg(directed[i].reg_sel, directed[i].value);
         end else begin
            typed_val.sample = directed[i].want_sample;
            typed_val.last = directed[i].want_last;
            send_tick(directed[i].start, directed[i].typed, typed_val);
         end
      end

      // random part: each phase sets every register, with extreme values in a rotation through the phases
      beats = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         write_reg(wsg_pkg::REG_WAVE_TYPE, 2'(ph % 4));
         case (ph % 5)
            0: val = 17'd1;
            1: val = 17'd65535;
            default: val = 17'($urandom_range(1, 300));
         endcase
         write_reg(wsg_pkg::REG_PERIOD, val);
         case (ph % 3)
            0: val = 17'd2;
            1: val = 17'd65535;
            default: val = 17'($urandom_range(0, 65535));
         endcase
         write_reg(wsg_pkg::REG_AMPLITUDE, val);
         case (ph % 6)
            0: val = 17'd65536;
            1: val = 17'($urandom_range(0, 17'h1ffff));
            default: val = 17'($urandom_range(1, 40));
         endcase
         write_reg(wsg_pkg::REG_COUNT, val);
         @(posedge clock);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            beats++;
            if (beats == 700) hold_req = 1;
            send_tick($urandom_range(0, 19) == 0, 0, typed_val);
         end
      end
      req.valid <= 1'b0;

      wait (pending_samples.size() == 0);
      repeat (80) @(posedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

>>> sim.f
+incdir+src
src/wsg_pkg.sv
src/wsg_stream_if.sv
src/wsg_divider.sv
src/wsg_front.sv
src/wsg_queue.sv
src/wsg_back.sv
src/waveform_sample_generator.sv
src/wsg_checker.sv
tb/tb.sv
